// ----- rtl/core/mbrtu_pkg.sv -----
package mbrtu_pkg;

  localparam int unsigned FrameBytes = 8;
  localparam int unsigned HeadBytes  = 6;
  localparam int unsigned PosWidth   = $clog2(FrameBytes);

  localparam logic [7:0]  FuncWriteSingle = 8'h06;
  localparam logic [15:0] CrcInit         = 16'hFFFF;
  localparam logic [15:0] CrcPoly         = 16'hA001;
  localparam logic [7:0]  DutyMax         = 8'd255;

  localparam logic [PosWidth-1:0] PosLast = PosWidth'(FrameBytes - 1);

  // Reply frame handed from the frame assembler to the reply serializer.
  typedef struct packed {
    logic                        load;
    logic [7:0]                  duty;
    logic [FrameBytes-1:0][7:0]  data;   // entry 0 goes out first
  } reply_t;

  // One byte of the Modbus CRC-16 (reflected), eight shift steps.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/modbus_rtu_write_register_slave.sv -----
// Channel     Dir  Handshake                         Payload
// s_axis      in   s_axis_tvalid_i / s_axis_tready_o tdata[7:0] rx_byte
// m_axis      out  m_axis_tvalid_o / m_axis_tready_i tdata[7:0] tx_byte, tdata[15:8] duty_value,
//                                                    tlast tx_last, tuser duty_update
// cfg         in   cfg_valid_i / cfg_ready_o         cfg_wdata_i[7:0] node address
//
// Each request byte is absorbed at its accepting edge; the first six also update the CRC
// and the frame store. A matching eighth byte loads the 8-byte reply shifter, which
// emits one byte per cycle while m_axis_tready_i is high.
// Reset clears the byte position, the CRC (to all ones), the reply shifter's
// busy flag, and sets the node address to 2.
// The only input stall: the eighth byte of a frame waits while the previous
// reply is still draining and not finishing in that same cycle.
module modbus_rtu_write_register_slave (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request bytes
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // reply bytes
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] tx_byte, [15:8] duty_value
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o,   // [0] duty_update
  // node address register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_wdata_i
);

  logic              rx_accept;
  logic              pos_last;
  logic              tx_busy;
  logic              tx_done;
  logic [7:0]        node_addr_q;
  mbrtu_pkg::reply_t reply;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_addr_q <= 8'd2;
    end else if (cfg_valid_i) begin
      node_addr_q <= cfg_wdata_i;
    end
  end

  // Hold the closing byte of a frame until the reply shifter is free or
  // sends its last byte in this cycle.
  assign s_axis_tready_o = !(pos_last && tx_busy && !tx_done);
  assign rx_accept       = s_axis_tvalid_i && s_axis_tready_o;

  mbrtu_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .node_addr_i (node_addr_q),
    .rx_accept_i (rx_accept),
    .rx_byte_i   (s_axis_tdata_i),
    .pos_last_o  (pos_last),
    .reply_o     (reply)
  );

  mbrtu_reply u_reply (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .reply_i       (reply),
    .busy_o        (tx_busy),
    .done_o        (tx_done),
    .tx_valid_o    (m_axis_tvalid_o),
    .tx_ready_i    (m_axis_tready_i),
    .tx_byte_o     (m_axis_tdata_o[7:0]),
    .tx_last_o     (m_axis_tlast_o),
    .duty_update_o (m_axis_tuser_o),
    .duty_value_o  (m_axis_tdata_o[15:8])
  );

endmodule

// ----- rtl/core/mbrtu_frame.sv -----
module mbrtu_frame (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [7:0]                    node_addr_i,
  input  logic                          rx_accept_i,
  input  logic [7:0]                    rx_byte_i,
  output logic                          pos_last_o,
  output mbrtu_pkg::reply_t             reply_o
);

  logic [mbrtu_pkg::PosWidth-1:0] pos_q, pos_d;
  logic [15:0]                    crc_q, crc_d;
  logic [7:0]                     store_q [mbrtu_pkg::HeadBytes];
  logic                           match;
  logic [7:0]                     duty;

  assign pos_last_o = (pos_q == mbrtu_pkg::PosLast);

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    if (rx_accept_i) begin
      pos_d = pos_q + 1'b1;
      if (pos_q < mbrtu_pkg::PosWidth'(mbrtu_pkg::HeadBytes)) begin
        crc_d = mbrtu_pkg::crc_step(crc_q, rx_byte_i);
      end else if (pos_last_o) begin
        crc_d = mbrtu_pkg::CrcInit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= mbrtu_pkg::CrcInit;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < int'(mbrtu_pkg::HeadBytes); i++) begin
      if (rx_accept_i && pos_q == mbrtu_pkg::PosWidth'(i)) begin
        store_q[i] <= rx_byte_i;
      end
    end
  end

  // Clamp the 16-bit register value to one byte.
  assign duty  = (store_q[4] != 8'h00) ? mbrtu_pkg::DutyMax : store_q[5];
  assign match = (store_q[0] == node_addr_i) && (store_q[1] == mbrtu_pkg::FuncWriteSingle);

  always_comb begin
    reply_o.load = rx_accept_i && pos_last_o && match;
    reply_o.duty = duty;
    for (int i = 0; i < int'(mbrtu_pkg::HeadBytes); i++) begin
      reply_o.data[i] = store_q[i];
    end
    reply_o.data[mbrtu_pkg::HeadBytes]     = crc_q[7:0];
    reply_o.data[mbrtu_pkg::HeadBytes + 1] = crc_q[15:8];
  end

endmodule

// ----- rtl/core/mbrtu_reply.sv -----
module mbrtu_reply (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mbrtu_pkg::reply_t             reply_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic                          tx_valid_o,
  input  logic                          tx_ready_i,
  output logic [7:0]                    tx_byte_o,
  output logic                          tx_last_o,
  output logic                          duty_update_o,
  output logic [7:0]                    duty_value_o
);

  logic                                  busy_q, busy_d;
  logic [mbrtu_pkg::PosWidth-1:0]        cnt_q, cnt_d;
  logic [mbrtu_pkg::FrameBytes-1:0][7:0] shift_q;
  logic [7:0]                            duty_q;
  logic                                  tx_accept;

  assign tx_accept = busy_q && tx_ready_i;
  assign done_o    = tx_accept && (cnt_q == mbrtu_pkg::PosLast);
  assign busy_o    = busy_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (reply_i.load) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (tx_accept) begin
      cnt_d = cnt_q + 1'b1;
      if (done_o) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (reply_i.load) begin
      shift_q <= reply_i.data;
      duty_q  <= reply_i.duty;
    end else if (tx_accept) begin
      shift_q <= {8'h00, shift_q[mbrtu_pkg::FrameBytes-1:1]};
    end
  end

  assign tx_valid_o    = busy_q;
  assign tx_byte_o     = shift_q[0];
  assign tx_last_o     = (cnt_q == mbrtu_pkg::PosLast);
  assign duty_update_o = (cnt_q == '0);
  assign duty_value_o  = duty_q;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int ClkPeriod      = 10;
  localparam int ResetCycles    = 10;
  localparam int DrainCycles    = 16;    // reply shifter depth plus margin
  localparam int LongHoldCycles = 400;
  localparam int WatchdogLimit  = 2000;
  localparam int FramesPerPhase = 5;
  localparam int NumPhases      = 5;

  // One reply byte as the master side presents it.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       duty_update;
    logic [7:0] duty_value;
  } reply_beat_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_valid = 1'b0;
  logic [7:0]  s_data  = 8'h00;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic        m_ready = 1'b0;
  logic [15:0] m_axis_tdata_o;   // [7:0] tx_byte, [15:8] duty_value
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;   // [0] duty_update
  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_wdata = 8'h00;

  // Stimulus control, owned by the sequencing initial block.
  logic        idle_on       = 1'b1;
  logic        long_hold_req = 1'b0;

  logic [7:0]  rx_pending[$];
  reply_beat_t reply_expect[$];
  int unsigned queued_bytes = 0;
  int unsigned fail_count   = 0;

  // Predictor state: mirrors the slave after reset.
  logic [7:0]                     listen_addr = 8'd2;
  logic [mbrtu_pkg::PosWidth-1:0] frame_pos   = '0;
  logic [7:0]                     head_store[mbrtu_pkg::HeadBytes];
  logic [15:0]                    crc_acc     = mbrtu_pkg::CrcInit;
  logic [7:0]                     duty_now    = 8'd0;

  // Driver and monitor bookkeeping.
  int          send_gap        = 0;
  int          recv_stall      = 0;
  logic        long_hold_taken = 1'b0;
  int          quiet_cycles    = 0;
  reply_beat_t reply_head;

  modbus_rtu_write_register_slave i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Modbus CRC-16: reflected, LSB shifted out first.
  function automatic logic [15:0] crc16_modbus_update(input logic [15:0] crc,
                                                      input logic [7:0]  b);
    logic [15:0] acc;
    acc = crc ^ {8'h00, b};
    repeat (8) acc = acc[0] ? ((acc >> 1) ^ mbrtu_pkg::CrcPoly) : (acc >> 1);
    return acc;
  endfunction

  // Absorb one accepted request byte; on a matching eighth byte queue the echo reply.
  function automatic void absorb_rx_byte(input logic [7:0] b);
    logic [15:0] reg_value;
    reply_beat_t beat;
    if (frame_pos < mbrtu_pkg::HeadBytes) begin
      head_store[frame_pos] = b;
      crc_acc = crc16_modbus_update(crc_acc, b);
    end
    if (frame_pos != mbrtu_pkg::PosLast) begin
      frame_pos = frame_pos + 1'b1;
    end else begin
      // Request CRC bytes are taken in but never checked.
      if (head_store[0] == listen_addr && head_store[1] == mbrtu_pkg::FuncWriteSingle) begin
        reg_value = {head_store[4], head_store[5]};
        duty_now  = (reg_value > mbrtu_pkg::DutyMax) ? mbrtu_pkg::DutyMax : reg_value[7:0];
        for (int k = 0; k < mbrtu_pkg::FrameBytes; k++) begin
          if (k < mbrtu_pkg::HeadBytes) begin
            beat.tx_byte = head_store[k];
          end else if (k == mbrtu_pkg::HeadBytes) begin
            beat.tx_byte = crc_acc[7:0];
          end else begin
            beat.tx_byte = crc_acc[15:8];
          end
          beat.tx_last     = (k == mbrtu_pkg::FrameBytes - 1);
          beat.duty_update = (k == 0);
          beat.duty_value  = duty_now;
          reply_expect.push_back(beat);
        end
      end
      frame_pos = '0;
      crc_acc   = mbrtu_pkg::CrcInit;
    end
  endfunction

  // Request driver: hold each byte until its transaction completes, gap in bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid  <= 1'b0;
      s_data   <= 8'h00;
      send_gap <= 0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        absorb_rx_byte(s_data);
      end
      if (!s_valid || s_axis_tready_o) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          s_valid  <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 9);
          s_valid  <= 1'b0;
        end else if (rx_pending.size() != 0) begin
          s_data  <= rx_pending.pop_front();
          s_valid <= 1'b1;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor: check each completed transaction against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready         <= 1'b0;
      recv_stall      <= 0;
      long_hold_taken <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_ready) begin
        if (reply_expect.size() == 0) begin
          $error("unexpected reply byte 0x%02h", m_axis_tdata_o[7:0]);
          fail_count++;
        end else begin
          reply_head = reply_expect.pop_front();
          if (m_axis_tdata_o[7:0] !== reply_head.tx_byte) begin
            $error("tx_byte: expected 0x%02h, got 0x%02h",
                   reply_head.tx_byte, m_axis_tdata_o[7:0]);
            fail_count++;
          end
          if (m_axis_tlast_o !== reply_head.tx_last) begin
            $error("tx_last: expected %0b, got %0b", reply_head.tx_last, m_axis_tlast_o);
            fail_count++;
          end
          if (m_axis_tuser_o !== reply_head.duty_update) begin
            $error("duty_update: expected %0b, got %0b",
                   reply_head.duty_update, m_axis_tuser_o);
            fail_count++;
          end
          if (m_axis_tdata_o[15:8] !== reply_head.duty_value) begin
            $error("duty_value: expected %0d, got %0d",
                   reply_head.duty_value, m_axis_tdata_o[15:8]);
            fail_count++;
          end
        end
      end
      // A long hold lets the reply shifter fill so that the slave stalls its input.
      if (long_hold_req && !long_hold_taken) begin
        long_hold_taken <= 1'b1;
        recv_stall      <= LongHoldCycles;
        m_ready         <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        m_ready    <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        recv_stall <= $urandom_range(0, 9);
        m_ready    <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Watchdog: abort when no channel completes a transaction for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    rx_pending.push_back(b);
    queued_bytes++;
  endtask

  // Queue one request frame; its trailing CRC bytes are random since they go unchecked.
  task automatic queue_frame(input logic [7:0] addr, input logic [7:0] func,
                             input logic [15:0] reg_addr, input logic [15:0] reg_value);
    queue_byte(addr);
    queue_byte(func);
    queue_byte(reg_addr[15:8]);
    queue_byte(reg_addr[7:0]);
    queue_byte(reg_value[15:8]);
    queue_byte(reg_value[7:0]);
    queue_byte(8'($urandom));
    queue_byte(8'($urandom));
  endtask

  // Favor the clamp boundary and the extremes of the register value.
  function automatic logic [15:0] pick_reg_value();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'h00FF;
      2:       return 16'h0100;
      3:       return 16'hFFFF;
      4, 5:    return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random_frames(input int count);
    int unsigned kind;
    int unsigned lead;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        queue_frame(listen_addr, mbrtu_pkg::FuncWriteSingle, 16'($urandom), pick_reg_value());
      end else if (kind < 16) begin
        queue_frame(listen_addr ^ 8'($urandom_range(1, 255)), mbrtu_pkg::FuncWriteSingle,
                    16'($urandom), pick_reg_value());
      end else if (kind < 18) begin
        queue_frame(listen_addr, mbrtu_pkg::FuncWriteSingle ^ 8'($urandom_range(1, 255)),
                    16'($urandom), pick_reg_value());
      end else if (kind == 18) begin
        repeat (mbrtu_pkg::FrameBytes) queue_byte(8'($urandom));
      end else begin
        // Broken sequence: stray bytes shift the framing, then pad back into step.
        lead = $urandom_range(1, mbrtu_pkg::FrameBytes - 1);
        repeat (lead) queue_byte(8'($urandom));
        queue_frame(listen_addr, mbrtu_pkg::FuncWriteSingle, 16'($urandom), pick_reg_value());
        while (queued_bytes % mbrtu_pkg::FrameBytes != 0) queue_byte(8'($urandom));
      end
    end
  endtask

  // Wait until every byte is sent and every reply byte has arrived, then let the slave settle.
  // Sample at the falling edge so that the driver's and monitor's updates have settled.
  task automatic wait_drained();
    forever begin
      @(negedge clk_i);
      if (rx_pending.size() == 0 && !s_valid && reply_expect.size() == 0) break;
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_node_addr(input logic [7:0] id);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_wdata <= id;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cfg_valid   <= 1'b0;
    listen_addr = id;
  endtask

  initial begin
    logic [7:0] next_id;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: smallest value, saturating all-ones value, address mismatch.
    queue_frame(listen_addr, mbrtu_pkg::FuncWriteSingle, 16'h0001, 16'h0000);
    queue_frame(listen_addr, mbrtu_pkg::FuncWriteSingle, 16'hFFFF, 16'hFFFF);
    queue_frame(listen_addr + 8'd1, mbrtu_pkg::FuncWriteSingle, 16'h0000, 16'h00FF);
    wait_drained();

    // Random phases, each under its own node address; extremes first.
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0:       next_id = 8'h00;
        1:       next_id = 8'hFF;
        default: next_id = 8'($urandom);
      endcase
      if (phase == 2) long_hold_req <= 1'b1;
      if (phase == NumPhases - 1) idle_on <= 1'b0;
      write_node_addr(next_id);
      queue_random_frames(FramesPerPhase);
      wait_drained();
    end

    if (fail_count == 0 && reply_expect.size() == 0 && rx_pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/mbrtu_pkg.sv
rtl/core/mbrtu_frame.sv
rtl/core/mbrtu_reply.sv
rtl/core/modbus_rtu_write_register_slave.sv
test/tb.sv
